// ----- src/matrix_3x3_compose_transform_macros.svh -----
// Assertion shorthands used by the controller RTL.
`ifndef MATRIX_3X3_COMPOSE_TRANSFORM_MACROS_SVH
`define MATRIX_3X3_COMPOSE_TRANSFORM_MACROS_SVH

// same-cycle implication
`define M3CT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define M3CT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/m3ct_pkg.sv -----
package m3ct_pkg;

  localparam int COEF_FRAC_BITS_DEF = 28;
  localparam int DATA_WIDTH_DEF     = 32;
  localparam int VAL_W              = 32;   // coefficient / coordinate width
  localparam int MAT_N              = 3;
  localparam int ELEMS              = 9;
  localparam int IDX_W              = 2;    // row / column index width

  localparam logic [IDX_W-1:0] LAST_IDX = 2'd2;

  // opcodes
  localparam logic [1:0] OP_WR_FACTOR = 2'd0;
  localparam logic [1:0] OP_WR_ACTIVE = 2'd1;
  localparam logic [1:0] OP_COMPOSE   = 2'd2;
  localparam logic [1:0] OP_TRANSFORM = 2'd3;

  // factor matrix selects
  localparam logic [1:0] FSEL_F1 = 2'd0;
  localparam logic [1:0] FSEL_F2 = 2'd1;
  localparam logic [1:0] FSEL_F3 = 2'd2;

  // result kinds
  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_COMPOSE = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic             wr;        // element write on this transaction
    logic             start;     // compose / transform accepted
    logic             issue;     // launch one dot product
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             stage;     // compose: 0 = F1*F2, 1 = P*F3
    logic             out_load;  // move result into output register
  } cmd_t;

  function automatic logic elem_ok(input logic [3:0] idx);
    return idx < 4'(ELEMS);
  endfunction

  function automatic logic [IDX_W-1:0] elem_row(input logic [3:0] idx);
    logic [IDX_W-1:0] r;
    case (idx)
      4'd3, 4'd4, 4'd5: r = 2'd1;
      4'd6, 4'd7, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] elem_col(input logic [3:0] idx);
    logic [IDX_W-1:0] c;
    case (idx)
      4'd1, 4'd4, 4'd7: c = 2'd1;
      4'd2, 4'd5, 4'd8: c = 2'd2;
      default:          c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- src/matrix_3x3_compose_transform.sv -----
// Channel  Dir  Fields (low bit first)
// -------  ---  -----------------------------------------------------------------
// s_*      in   tuser: opcode[1:0]
//               tdata: factor_select[1:0] element_index[5:2] element_value[37:6]
//                      point_x[69:38] point_y[101:70] point_z[133:102] pad[135:134]
// m_*      out  tuser: result_kind[0] saturated[1]
//               tdata: out_x[31:0] out_y[63:32] out_z[95:64]
//
// Element writes (opcodes 0/1) produce no transaction.
// Transform: three lane multipliers issue one matrix row per cycle; a point goes through
//   accept, one issue per matrix row, a sum state and a load state before the next accept.
// Compose: 18 dot products on the same multiplier row.
// rst (synchronous) clears control only; matrices are undefined until written.
//   s_tready stays low while rst is high.
// A result waits in the output register; element writes are still taken then,
//   and a following compose/transform runs but holds before loading its result.
module matrix_3x3_compose_transform
  import m3ct_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // factor_select, element_index, element_value, x, y, z
  input  logic [1:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // out_x, out_y, out_z
  output logic [1:0]   m_tuser    // result_kind, saturated
);

  cmd_t                    cmd;
  logic                    result_kind;
  logic                    saturated;
  logic signed [VAL_W-1:0] out_x, out_y, out_z;

  // controller: sequences issues over the shared multiplier row
  m3ct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser[1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // datapath: matrix storage, lane multipliers, sum/clip, output register
  m3ct_datapath #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .DATA_WIDTH     (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (s_tuser[1:0]),
    .factor_select (s_tdata[1:0]),
    .element_index (s_tdata[5:2]),
    .element_value (s_tdata[37:6]),
    .point_x       (s_tdata[69:38]),
    .point_y       (s_tdata[101:70]),
    .point_z       (s_tdata[133:102]),
    .result_kind   (result_kind),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .saturated     (saturated)
  );

  assign m_tdata = {out_z, out_y, out_x};
  assign m_tuser = {saturated, result_kind};

endmodule

// ----- src/m3ct_ctrl.sv -----
`include "matrix_3x3_compose_transform_macros.svh"

module m3ct_ctrl
  import m3ct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [1:0] opcode,
  output logic       m_tvalid,
  input  logic       m_tready,
  output cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] row, row_next;
  logic [IDX_W-1:0] col, col_next;
  logic             stage, stage_next;
  logic             is_comp;
  logic             accept;
  logic             out_free;
  logic             at_origin;

  // no transaction is taken while reset is held
  assign s_tready  = (state == ST_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign at_origin = (row == '0) && (col == '0) && !stage;

  always_comb begin
    cmd          = '0;
    cmd.wr       = accept && (opcode == OP_WR_FACTOR || opcode == OP_WR_ACTIVE);
    cmd.start    = accept && (opcode == OP_COMPOSE || opcode == OP_TRANSFORM);
    cmd.issue    = (state == ST_RUN);
    cmd.row      = row;
    cmd.col      = col;
    cmd.stage    = stage;
    cmd.out_load = (state == ST_FIN) && out_free;
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    stage_next = stage;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (is_comp) begin
          if (col == LAST_IDX) begin
            col_next = '0;
            if (row == LAST_IDX) begin
              row_next = '0;
              if (stage) begin
                stage_next = 1'b0;
                state_next = ST_DRAIN;
              end else begin
                stage_next = 1'b1;
              end
            end else begin
              row_next = row + 2'd1;
            end
          end else begin
            col_next = col + 2'd1;
          end
        end else begin
          if (row == LAST_IDX) begin
            row_next   = '0;
            state_next = ST_DRAIN;
          end else begin
            row_next = row + 2'd1;
          end
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      row      <= '0;
      col      <= '0;
      stage    <= 1'b0;
      is_comp  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      stage <= stage_next;
      if (cmd.start) is_comp <= (opcode == OP_COMPOSE);
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `M3CT_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, !m_tvalid || m_tready, "result overwritten")
  `M3CT_ASSERT_NXT(a_start_run, clk, rst, cmd.start, state == ST_RUN && at_origin, "dirty start")
  `M3CT_ASSERT_IMP(a_xform_row, clk, rst, state == ST_RUN && !is_comp, col == '0 && !stage, "col moved")
  `M3CT_ASSERT_IMP(a_idx_range, clk, rst, state == ST_RUN, row != 2'd3 && col != 2'd3, "index overrun")

endmodule

// ----- src/m3ct_datapath.sv -----
module m3ct_datapath
  import m3ct_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  logic [1:0]              opcode,
  input  logic [1:0]              factor_select,
  input  logic [3:0]              element_index,
  input  logic signed [VAL_W-1:0] element_value,
  input  logic signed [VAL_W-1:0] point_x,
  input  logic signed [VAL_W-1:0] point_y,
  input  logic signed [VAL_W-1:0] point_z,
  output logic                    result_kind,
  output logic signed [VAL_W-1:0] out_x,
  output logic signed [VAL_W-1:0] out_y,
  output logic signed [VAL_W-1:0] out_z,
  output logic                    saturated
);

  localparam int PROD_W = 2 * VAL_W;
  localparam int SH_W   = PROD_W - COEF_FRAC_BITS;
  localparam int SUM_W  = SH_W + 2;
  localparam int CLIP_W = (DATA_WIDTH > VAL_W) ? VAL_W : DATA_WIDTH;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-CLIP_W+1){1'b0}}, {(CLIP_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  // Lane c holds column c (f1, pp, act) or row c (f2, f3), indexed by the other axis.
  logic signed [VAL_W-1:0]  f1  [MAT_N][MAT_N];
  logic signed [VAL_W-1:0]  f2  [MAT_N][MAT_N];
  logic signed [VAL_W-1:0]  f3  [MAT_N][MAT_N];
  logic signed [VAL_W-1:0]  pp  [MAT_N][MAT_N];
  logic signed [VAL_W-1:0]  act [MAT_N][MAT_N];
  logic signed [VAL_W-1:0]  pt  [MAT_N];
  logic signed [VAL_W-1:0]  res [MAT_N];

  logic signed [VAL_W-1:0]  lhs  [MAT_N];
  logic signed [VAL_W-1:0]  rhs  [MAT_N];
  logic signed [PROD_W-1:0] prod [MAT_N];

  logic                     is_comp;
  logic                     p_valid;
  logic [IDX_W-1:0]         p_row, p_col;
  logic                     p_stage;
  logic                     sat;

  logic [IDX_W-1:0]         wr_row, wr_col;
  logic                     wr_ok;
  logic signed [SUM_W-1:0]  sum;
  logic signed [VAL_W-1:0]  sum_clip;
  logic                     clipped;

  assign wr_row = elem_row(element_index);
  assign wr_col = elem_col(element_index);
  assign wr_ok  = elem_ok(element_index);

  // operand select, one multiplier per lane
  always_comb begin
    for (int c = 0; c < MAT_N; c++) begin
      if (!is_comp) begin
        lhs[c] = act[c][cmd.row];
        rhs[c] = pt[c];
      end else if (cmd.stage) begin
        lhs[c] = pp[c][cmd.row];
        rhs[c] = f3[c][cmd.col];
      end else begin
        lhs[c] = f1[c][cmd.row];
        rhs[c] = f2[c][cmd.col];
      end
    end
  end

  // floor-shift each product, exact sum, clip
  always_comb begin
    sum = '0;
    for (int c = 0; c < MAT_N; c++) begin
      sum = sum + {{2{prod[c][PROD_W-1]}}, prod[c][PROD_W-1:COEF_FRAC_BITS]};
    end
    clipped = 1'b1;
    if (sum > SAT_HI) begin
      sum_clip = SAT_HI[VAL_W-1:0];
    end else if (sum < SAT_LO) begin
      sum_clip = SAT_LO[VAL_W-1:0];
    end else begin
      sum_clip = sum[VAL_W-1:0];
      clipped  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      for (int c = 0; c < MAT_N; c++) begin
        prod[c] <= lhs[c] * rhs[c];
      end
      p_row   <= cmd.row;
      p_col   <= cmd.col;
      p_stage <= cmd.stage;
    end

    if (cmd.start) begin
      is_comp <= (opcode == OP_COMPOSE);
      pt[0]   <= point_x;
      pt[1]   <= point_y;
      pt[2]   <= point_z;
      sat     <= 1'b0;
    end else if (p_valid && clipped) begin
      sat <= 1'b1;
    end

    if (cmd.wr && wr_ok) begin
      if (opcode == OP_WR_ACTIVE) begin
        act[wr_col][wr_row] <= element_value;
      end else begin
        unique case (factor_select)
          FSEL_F1: f1[wr_col][wr_row] <= element_value;
          FSEL_F2: f2[wr_row][wr_col] <= element_value;
          FSEL_F3: f3[wr_row][wr_col] <= element_value;
          default: ;
        endcase
      end
    end else if (p_valid) begin
      if (!is_comp) begin
        res[p_row] <= sum_clip;
      end else if (p_stage) begin
        act[p_col][p_row] <= sum_clip;
      end else begin
        pp[p_col][p_row] <= sum_clip;
      end
    end

    if (cmd.out_load) begin
      result_kind <= is_comp ? KIND_COMPOSE : KIND_POINT;
      out_x       <= is_comp ? '0 : res[0];
      out_y       <= is_comp ? '0 : res[1];
      out_z       <= is_comp ? '0 : res[2];
      saturated   <= sat;
    end
  end

endmodule
